>>> rtl/llh_pkg.sv
`default_nettype none

package llh_pkg;

  localparam int LENGTH_BITS   = 10;
  localparam int COUNT_OUT_BITS = 24;
  localparam int PRODUCT_BITS  = 34;
  localparam int LINES_BITS    = 32;
  localparam int CHARS_BITS    = 40;
  // widest bin index (16 bits) times widest count (32 bits)
  localparam int PROD_EXT_BITS = 48;

  localparam int CMD_FIFO_DEPTH = 4;

  localparam logic [1:0] OP_TEXT   = 2'd0;
  localparam logic [1:0] OP_EOF    = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  localparam logic ROW_BIN    = 1'b0;
  localparam logic ROW_TOTALS = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic                      row_kind;
    logic [LENGTH_BITS-1:0]    length_value;
    logic [COUNT_OUT_BITS-1:0] line_count;
    logic [PRODUCT_BITS-1:0]   char_product;
    logic [LINES_BITS-1:0]     total_lines;
    logic [CHARS_BITS-1:0]     total_chars;
    logic                      last_row;
  } out_item_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_INC,
    B_SCAN,
    B_MUL,
    B_ROW,
    B_TOTAL
  } back_state_t;

endpackage

`default_nettype wire

>>> rtl/llh_ram.sv
`default_nettype none

module llh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/llh_cmd_fifo.sv
`default_nettype none

module llh_cmd_fifo #(
  parameter int W     = 11,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              fifo_full,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              fifo_valid
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [W-1:0]        slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;

  logic do_wr;
  logic do_rd;

  assign fifo_full  = (fill == CNT_BITS'(DEPTH));
  assign fifo_valid = (fill != '0);
  assign rd_data    = slots[rd_ptr];
  assign do_wr      = wr_en && !fifo_full;
  assign do_rd      = rd_en && fifo_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CNT_BITS'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CNT_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/llh_front.sv
`default_nettype none

module llh_front #(
  parameter int MAX_LINE = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire llh_pkg::in_item_t  item,
  output logic                    full,
  input  wire logic               clearing,
  output logic                    cmd_wr,
  output logic [$clog2(MAX_LINE):0] cmd_data,
  input  wire logic               cmd_full
);

  import llh_pkg::*;

  localparam int AW = $clog2(MAX_LINE);

  logic [AW-1:0] current_length;
  logic [AW-1:0] current_length_next;
  logic          accept;

  assign full   = cmd_full || clearing;
  assign accept = push && !full;

  // cmd word: top bit set = report, else bin increment at the index below
  always_comb begin
    current_length_next = current_length;
    cmd_wr              = 1'b0;
    cmd_data            = {1'b0, current_length};
    if (accept) begin
      case (item.op)
        OP_TEXT: begin
          if (item.byte_value == NEWLINE_BYTE) begin
            cmd_wr              = 1'b1;
            current_length_next = '0;
          end else if (current_length != AW'(MAX_LINE - 1)) begin
            current_length_next = current_length + AW'(1);
          end
        end
        OP_EOF: begin
          current_length_next = '0;
        end
        OP_REPORT: begin
          cmd_wr   = 1'b1;
          cmd_data = {1'b1, AW'(0)};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_length <= '0;
    end else begin
      current_length <= current_length_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/llh_back.sv
`default_nettype none

module llh_back #(
  parameter int MAX_LINE   = 1024,
  parameter int COUNT_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cmd_valid,
  input  wire logic [$clog2(MAX_LINE):0] cmd_data,
  output logic                        cmd_pop,
  output logic                        clearing,
  output logic                        out_valid,
  output llh_pkg::out_item_t          out_item,
  input  wire logic                   out_pop
);

  import llh_pkg::*;

  localparam int AW  = $clog2(MAX_LINE);
  localparam int PW  = $clog2(MAX_LINE + 1);
  localparam int CB  = COUNT_BITS;
  localparam int PRW = AW + CB;

  back_state_t state, state_next;

  logic [AW-1:0]         clr_addr, clr_addr_next;
  logic [AW-1:0]         bin_addr, bin_addr_next;
  logic [PW-1:0]         ptr, ptr_next;
  logic [CB-1:0]         cnt, cnt_next;
  logic [PRW-1:0]        prod, prod_next;
  logic [LINES_BITS-1:0] running_lines, running_lines_next;
  logic [CHARS_BITS-1:0] running_chars, running_chars_next;
  logic                  out_valid_next;
  out_item_t             out_item_next;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CB-1:0] wr_data, rd_data;

  logic                     out_free;
  logic [PROD_EXT_BITS-1:0] prod_ext;
  logic [PRODUCT_BITS-1:0]  prod_sat;
  logic [LINES_BITS:0]      lines_sum;
  logic [CHARS_BITS:0]      chars_sum;
  logic [LINES_BITS-1:0]    lines_sat;
  logic [CHARS_BITS-1:0]    chars_sat;

  llh_ram #(
    .WIDTH (CB),
    .DEPTH (MAX_LINE)
  ) u_bins (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign clearing = (state == B_CLEAR);
  assign out_free = !out_valid || out_pop;

  assign prod_ext  = PROD_EXT_BITS'(prod);
  assign prod_sat  = (|prod_ext[PROD_EXT_BITS-1:PRODUCT_BITS]) ? '1
                                                               : prod_ext[PRODUCT_BITS-1:0];
  assign lines_sum = {1'b0, running_lines} + (LINES_BITS + 1)'(cnt);
  assign chars_sum = {1'b0, running_chars} + (CHARS_BITS + 1)'(prod_sat);
  assign lines_sat = lines_sum[LINES_BITS] ? '1 : lines_sum[LINES_BITS-1:0];
  assign chars_sat = chars_sum[CHARS_BITS] ? '1 : chars_sum[CHARS_BITS-1:0];

  always_comb begin
    state_next         = state;
    clr_addr_next      = clr_addr;
    bin_addr_next      = bin_addr;
    ptr_next           = ptr;
    cnt_next           = cnt;
    prod_next          = prod;
    running_lines_next = running_lines;
    running_chars_next = running_chars;
    out_valid_next     = out_valid && !out_pop;
    out_item_next      = out_item;
    rd_en              = 1'b0;
    rd_addr            = bin_addr;
    wr_en              = 1'b0;
    wr_addr            = bin_addr;
    wr_data            = '0;
    cmd_pop            = 1'b0;
    case (state)
      B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        if (clr_addr == AW'(MAX_LINE - 1)) begin
          state_next = B_IDLE;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd_data[AW]) begin
            if (ptr == PW'(MAX_LINE)) begin
              state_next = B_TOTAL;
            end else begin
              rd_en         = 1'b1;
              rd_addr       = ptr[AW-1:0];
              bin_addr_next = ptr[AW-1:0];
              state_next    = B_SCAN;
            end
          end else begin
            rd_en         = 1'b1;
            rd_addr       = cmd_data[AW-1:0];
            bin_addr_next = cmd_data[AW-1:0];
            state_next    = B_INC;
          end
        end
      end
      B_INC: begin
        wr_en      = 1'b1;
        wr_data    = (&rd_data) ? rd_data : rd_data + CB'(1);
        state_next = B_IDLE;
      end
      B_SCAN: begin
        if (rd_data != '0) begin
          cnt_next   = rd_data;
          state_next = B_MUL;
        end else if (bin_addr == AW'(MAX_LINE - 1)) begin
          state_next = B_TOTAL;
        end else begin
          bin_addr_next = bin_addr + AW'(1);
          rd_en         = 1'b1;
          rd_addr       = bin_addr + AW'(1);
        end
      end
      B_MUL: begin
        prod_next  = PRW'(bin_addr) * PRW'(cnt);
        state_next = B_ROW;
      end
      B_ROW: begin
        if (out_free) begin
          out_valid_next             = 1'b1;
          out_item_next.row_kind     = ROW_BIN;
          out_item_next.length_value = LENGTH_BITS'(bin_addr);
          out_item_next.line_count   = COUNT_OUT_BITS'(cnt);
          out_item_next.char_product = prod_sat;
          out_item_next.total_lines  = lines_sat;
          out_item_next.total_chars  = chars_sat;
          out_item_next.last_row     = 1'b0;
          running_lines_next         = lines_sat;
          running_chars_next         = chars_sat;
          ptr_next                   = PW'(bin_addr) + PW'(1);
          state_next                 = B_IDLE;
        end
      end
      B_TOTAL: begin
        if (out_free) begin
          out_valid_next             = 1'b1;
          out_item_next.row_kind     = ROW_TOTALS;
          out_item_next.length_value = '0;
          out_item_next.line_count   = '0;
          out_item_next.char_product = '0;
          out_item_next.total_lines  = running_lines;
          out_item_next.total_chars  = running_chars;
          out_item_next.last_row     = 1'b1;
          running_lines_next         = '0;
          running_chars_next         = '0;
          ptr_next                   = '0;
          state_next                 = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_CLEAR;
      clr_addr      <= '0;
      ptr           <= '0;
      running_lines <= '0;
      running_chars <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      clr_addr      <= clr_addr_next;
      ptr           <= ptr_next;
      running_lines <= running_lines_next;
      running_chars <= running_chars_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    bin_addr <= bin_addr_next;
    cnt      <= cnt_next;
    prod     <= prod_next;
    out_item <= out_item_next;
  end

endmodule

`default_nettype wire

>>> rtl/line_length_histogram_top.sv
// Line length histogram.
// Input channel (push/full): one transaction per text byte, end-of-file mark
// or report request. Text bytes are taken one per cycle while full is low;
// the front end keeps the running length of the open line and queues a bin
// increment on each newline and a request on each report transaction, in a
// 4-deep command queue. The back end owns the bin memory (MAX_LINE x
// COUNT_BITS, one-port-each RAM with registered read). A bin increment is a
// read-modify-write. A report transaction walks the bins from where the last
// one stopped (read, test, multiply, accumulate), skipping empty bins, and
// yields the next non-empty bin row; once the walk reaches the end, it yields
// the totals row instead.
// Each report transaction yields one result transaction on the result channel
// (empty/pop), held in an output register. A stalled receiver stops the back
// end as soon as the next row is ready; full rises once the command queue
// has filled behind it.
// Reset: synchronous. After rst falls, a clearing pass writes zero to every
// bin, during which full stays high. Open line length, report walk and
// running totals return to zero; empty goes high.
`default_nettype none

module line_length_histogram_top #(
  parameter int MAX_LINE   = 1024,
  parameter int COUNT_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire llh_pkg::in_item_t   item,
  output logic                     full,
  input  wire logic                pop,
  output llh_pkg::out_item_t       result,
  output logic                     empty
);

  import llh_pkg::*;

  localparam int AW = $clog2(MAX_LINE);

  // front -> queue
  logic          cmd_wr;
  logic [AW:0]   cmd_wdata;
  logic          cmd_full;
  // queue -> back
  logic          cmd_valid;
  logic [AW:0]   cmd_rdata;
  logic          cmd_pop;
  // back status
  logic          clearing;
  logic          out_valid;

  llh_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .clearing (clearing),
    .cmd_wr   (cmd_wr),
    .cmd_data (cmd_wdata),
    .cmd_full (cmd_full)
  );

  llh_cmd_fifo #(
    .W     (AW + 1),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (cmd_wr),
    .wr_data    (cmd_wdata),
    .fifo_full  (cmd_full),
    .rd_en      (cmd_pop),
    .rd_data    (cmd_rdata),
    .fifo_valid (cmd_valid)
  );

  llh_back #(
    .MAX_LINE   (MAX_LINE),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_item  (result),
    .out_pop   (pop)
  );

  // result register is the whole result queue
  assign empty = !out_valid;

endmodule

`default_nettype wire

>>> rtl/llh_checker.sv
`default_nettype none

module llh_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               full,
  input wire logic               pop,
  input wire llh_pkg::out_item_t result,
  input wire logic               empty
);

  import llh_pkg::*;

  // clearing pass follows reset
  a_reset_full: assert property (@(posedge clk) rst |=> full)
    else $error("input accepted right after reset");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result changed");

  a_totals_shape: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((result.last_row == result.row_kind) &&
                (!result.last_row || (result.length_value == '0 &&
                 result.line_count == '0 && result.char_product == '0))))
    else $error("malformed totals row");

endmodule

bind line_length_histogram_top llh_checker u_llh_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .pop    (pop),
  .result (result),
  .empty  (empty)
);

`default_nettype wire
